// ===== design/sfc_pkg.sv =====
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types and codes for the substring find-and-count block: the payload
// structs of the item and result channels, opcodes, status codes and the
// configuration register indexes.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int unsigned PATTERN_MAX_DEF = 64;
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned CFG_W  = 32;

  // Item opcodes.
  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_MAX_COUNT = 1'b0;
  localparam logic CFG_DIRECTION = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [CHAR_W-1:0] ch;
    logic              is_last;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] match_position;
    logic [CNT_W-1:0] match_count;
    logic [1:0]       status;
  } out_item_t;

endpackage

// ===== design/substring_find_and_count.sv =====
// ----------------------------------------------------------------------------
// substring_find_and_count
// Exact substring search with greedy non-overlapping occurrence count.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle while in_ready is high, pattern or
// text alike: each text character updates a shift-and vector of partial
// matches with one compare per pattern position, so the cost of a cycle is
// set by that compare row and the selection of the bit at the pattern's end.
// Results, registered when the last text character is taken, wait in an output
// register backed by one skid register, so the input keeps flowing while a
// result is held; in_ready drops only when both are full. Load the pattern
// first (opcode 0, is_last on its final character); in right-to-left mode
// feed both pattern and text reversed and the reported position is given in
// original text order.
// ----------------------------------------------------------------------------
module substring_find_and_count
  import sfc_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int unsigned IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  // Configuration.
  logic [CFG_W-1:0] max_count_r;
  logic             direction_r;

  // Pattern and scan state.
  logic [CHAR_W-1:0]      store_r [PATTERN_MAX];
  logic [LEN_W-1:0]       pat_len_r, pat_len_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   closed_r, closed_nxt;
  logic [PATTERN_MAX-1:0] pm_r, pm_nxt;
  logic [POS_W-1:0]       text_pos_r, text_pos_nxt;
  logic [COUNT_WIDTH-1:0] hits_r, hits_nxt;
  logic [POS_W-1:0]       first_end_r, first_end_nxt;

  // Result buffer.
  logic      out_valid_r, skid_valid_r;
  out_item_t out_r, skid_r;

  logic                   in_fire;
  logic                   is_text;
  logic                   search_en;
  logic [PATTERN_MAX-1:0] len_mask;
  logic [PATTERN_MAX-1:0] tail_sel;
  logic [PATTERN_MAX-1:0] pm_shift;
  logic                   hit;
  logic                   hit_cnt;
  logic                   can_inc;
  logic                   first_take;
  logic [COUNT_WIDTH-1:0] hits_upd;
  logic [POS_W-1:0]       first_upd;
  logic [LEN_W-1:0]       wr_idx;
  logic                   store_we;
  logic                   push;
  logic                   pop;
  out_item_t              res;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign is_text  = (in_data.opcode == OP_TEXT);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Shift-and row: bit i means the last i+1 text characters match the
  // first i+1 pattern characters. Positions past the pattern stay zero.
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pos
    assign len_mask[i] = (LEN_W'(i) < pat_len_r);
    assign tail_sel[i] = (LEN_W'(i + 1) == pat_len_r);
    if (i == 0) begin : g_head
      assign pm_shift[i] = len_mask[i] && (store_r[i] == in_data.ch);
    end else begin : g_body
      assign pm_shift[i] = pm_r[i-1] && len_mask[i] && (store_r[i] == in_data.ch);
    end
  end

  assign search_en  = (pat_len_r != '0) && !ovf_r;
  assign hit        = |(pm_shift & tail_sel);
  assign hit_cnt    = in_fire && is_text && search_en && hit;
  assign can_inc    = (CMP_W'(hits_r) < CMP_W'(max_count_r)) && (hits_r != '1);
  assign first_take = (hits_r == '0) && (max_count_r != '0);
  assign hits_upd   = (hit_cnt && can_inc) ? hits_r + COUNT_WIDTH'(1) : hits_r;
  assign first_upd  = (hit_cnt && first_take) ? text_pos_r : first_end_r;

  assign wr_idx   = closed_r ? '0 : pat_len_r;
  assign store_we = in_fire && !is_text && (wr_idx < LEN_W'(PATTERN_MAX));

  always_comb begin
    pat_len_nxt   = pat_len_r;
    ovf_nxt       = ovf_r;
    closed_nxt    = closed_r;
    pm_nxt        = pm_r;
    text_pos_nxt  = text_pos_r;
    hits_nxt      = hits_upd;
    first_end_nxt = first_upd;
    push          = 1'b0;

    res                = '0;
    res.match_count    = CNT_W'(hits_upd);
    if (ovf_r) begin
      res.status = STATUS_OVERFLOW;
    end else if (pat_len_r == '0) begin
      res.status = STATUS_EMPTY;
    end else begin
      res.status = STATUS_OK;
    end
    res.found = (res.status == STATUS_OK) && (max_count_r != '0) && (hits_upd != '0);
    if (!res.found) begin
      res.match_count = '0;
    end else if (direction_r) begin
      res.match_position = text_pos_r - first_upd;
    end else begin
      res.match_position = first_upd - (POS_W'(pat_len_r) - POS_W'(1));
    end

    if (in_fire) begin
      if (!is_text) begin
        if (closed_r) begin
          // A new pattern abandons any text in progress.
          pat_len_nxt   = '0;
          ovf_nxt       = 1'b0;
          pm_nxt        = '0;
          text_pos_nxt  = '0;
          hits_nxt      = '0;
          first_end_nxt = '0;
        end
        if (wr_idx < LEN_W'(PATTERN_MAX)) begin
          pat_len_nxt = wr_idx + LEN_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        closed_nxt = in_data.is_last;
      end else begin
        closed_nxt = 1'b1;
        if (search_en) begin
          // A full match clears the row so the next one cannot overlap it.
          pm_nxt = hit ? '0 : pm_shift;
        end
        if (!in_data.is_last) begin
          text_pos_nxt = text_pos_r + POS_W'(1);
        end else begin
          push          = 1'b1;
          pm_nxt        = '0;
          text_pos_nxt  = '0;
          hits_nxt      = '0;
          first_end_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[wr_idx[IDX_W-1:0]] <= in_data.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_count_r <= '1;
      direction_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_COUNT: max_count_r <= cfg_wdata;
        CFG_DIRECTION: direction_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r   <= '0;
      ovf_r       <= 1'b0;
      closed_r    <= 1'b1;
      pm_r        <= '0;
      text_pos_r  <= '0;
      hits_r      <= '0;
      first_end_r <= '0;
    end else begin
      pat_len_r   <= pat_len_nxt;
      ovf_r       <= ovf_nxt;
      closed_r    <= closed_nxt;
      pm_r        <= pm_nxt;
      text_pos_r  <= text_pos_nxt;
      hits_r      <= hits_nxt;
      first_end_r <= first_end_nxt;
    end
  end

  assign pop = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload of the result buffer.
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the output register is empty");

  a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pat_len_r <= LEN_W'(PATTERN_MAX))
    else $error("pattern length beyond the store");

  a_row_in_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    (pm_r & ~len_mask) == '0)
    else $error("partial match set beyond the pattern end");

  a_scan_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_text && in_data.is_last) |=> (text_pos_r == '0 && hits_r == '0 && pm_r == '0))
    else $error("scan state not cleared after the last text word");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.found) |-> (out_r.status == STATUS_OK && out_r.match_count != '0))
    else $error("found result without ok status or count");
`endif

endmodule

// ===== tb/substring_find_and_count_tb.sv =====
// ----------------------------------------------------------------------------
// substring_find_and_count_tb
// Self-checking bench for the substring search block. Pattern and text words
// are pushed through the valid/ready input while an in-bench shift-and
// predictor computes each report; the reports that come out are compared
// field by field, in order, against the predicted ones. Directed cases come
// first, then a long run of random patterns and texts over small random
// alphabets, with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module substring_find_and_count_tb;
  import sfc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [CHAR_W-1:0] char_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  substring_find_and_count dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor state, a copy of what the block keeps.
  char_t                      pat_mem [PATTERN_MAX_DEF];
  int unsigned                pat_len;
  bit                         pat_ovf;
  bit                         pat_closed;
  logic [PATTERN_MAX_DEF-1:0] partial;
  logic [POS_W-1:0]           text_pos;
  logic [CNT_W-1:0]           hits;
  logic [POS_W-1:0]           first_end;
  logic [CFG_W-1:0]           max_count_reg;
  bit                         dir_reg;

  out_item_t   due_reports [$];
  int unsigned fault_count;
  int unsigned words_sent;
  bit          idle_on;
  bit          hold_req;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("substring_find_and_count: mismatch");
    $finish;
  end

  function automatic void clear_scan_state();
    partial   = '0;
    text_pos  = '0;
    hits      = '0;
    first_end = '0;
  endfunction

  function automatic void shift_and_step(in_item_t w);
    out_item_t   r;
    int unsigned m;
    int          i;
    if (w.opcode == OP_PATTERN) begin
      if (pat_closed) begin
        pat_len    = 0;
        pat_ovf    = 1'b0;
        pat_closed = 1'b0;
        clear_scan_state();
      end
      if (pat_len < PATTERN_MAX_DEF) begin
        pat_mem[pat_len] = w.ch;
        pat_len++;
      end else begin
        pat_ovf = 1'b1;
      end
      if (w.is_last) pat_closed = 1'b1;
      return;
    end
    pat_closed = 1'b1;
    m = pat_len;
    if (m > 0 && !pat_ovf) begin
      for (i = m - 1; i > 0; i--) partial[i] = partial[i-1] && (pat_mem[i] == w.ch);
      partial[0] = (pat_mem[0] == w.ch);
      // A full match restarts the search after it, so hits never overlap.
      if (partial[m-1]) begin
        if (hits == 0 && max_count_reg != 0) first_end = text_pos;
        if (hits < max_count_reg) hits++;
        partial = '0;
      end
    end
    if (!w.is_last) begin
      text_pos++;
      return;
    end
    r = '0;
    if (pat_ovf) r.status = STATUS_OVERFLOW;
    else if (m == 0) r.status = STATUS_EMPTY;
    else r.status = STATUS_OK;
    if (r.status == STATUS_OK && max_count_reg != 0 && hits != 0) begin
      r.found       = 1'b1;
      r.match_count = hits;
      if (dir_reg) r.match_position = text_pos - first_end;
      else r.match_position = first_end - POS_W'(m - 1);
    end
    due_reports.push_back(r);
    clear_scan_state();
  endfunction

  // Result checker: every accepted report is compared with the oldest one due.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_reports.size() == 0) begin
        $display("%0t: unexpected report: expected none, actual %h", $time, out_data);
        fault_count++;
      end else begin
        want = due_reports.pop_front();
        if (out_data.found !== want.found) begin
          $display("%0t: found: expected %h, actual %h", $time, want.found, out_data.found);
          fault_count++;
        end
        if (out_data.match_position !== want.match_position) begin
          $display("%0t: match_position: expected %h, actual %h", $time,
                   want.match_position, out_data.match_position);
          fault_count++;
        end
        if (out_data.match_count !== want.match_count) begin
          $display("%0t: match_count: expected %h, actual %h", $time,
                   want.match_count, out_data.match_count);
          fault_count++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status: expected %h, actual %h", $time, want.status, out_data.status);
          fault_count++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic op, input char_t c, input bit last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{opcode: op, ch: c, is_last: last};
    do @(posedge clk); while (!in_ready);
    shift_and_step('{opcode: op, ch: c, is_last: last});
    words_sent++;
  endtask

  task automatic send_str(input logic op, input string s, input bit close);
    int i;
    for (i = 0; i < s.len(); i++) send_word(op, s[i], close && i == s.len() - 1);
  endtask

  // Items that give no report may still be in flight when the queue empties,
  // so the bench keeps waiting after that before the block is treated as idle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_COUNT) max_count_reg = val;
    else dir_reg = val[0];
    @(posedge clk);
  endtask

  task automatic test_empty_pattern();
    send_str(OP_TEXT, "q", 1'b1);
  endtask

  task automatic test_basic_search();
    send_str(OP_PATTERN, "aba", 1'b1);
    send_str(OP_TEXT, "xababa", 1'b1);
  endtask

  task automatic test_char_extremes();
    send_word(OP_PATTERN, 8'h00, 1'b0);
    send_word(OP_PATTERN, 8'hff, 1'b1);
    send_word(OP_TEXT, 8'hff, 1'b0);
    send_word(OP_TEXT, 8'h00, 1'b0);
    send_word(OP_TEXT, 8'hff, 1'b0);
    send_word(OP_TEXT, 8'h00, 1'b1);
  endtask

  task automatic test_pattern_longer_than_text();
    send_str(OP_PATTERN, "abcd", 1'b1);
    send_str(OP_TEXT, "ab", 1'b1);
  endtask

  // The first text word closes a pattern that was never marked as complete.
  task automatic test_text_closes_pattern();
    send_str(OP_PATTERN, "ab", 1'b0);
    send_str(OP_TEXT, "zab", 1'b1);
  endtask

  // A new pattern discards the text that was still being scanned.
  task automatic test_abandoned_text();
    send_str(OP_PATTERN, "a", 1'b1);
    send_str(OP_TEXT, "aa", 1'b0);
    send_str(OP_PATTERN, "b", 1'b1);
    send_str(OP_TEXT, "b", 1'b1);
  endtask

  task automatic test_max_count();
    wait_drained();
    write_reg(CFG_MAX_COUNT, '0);
    send_str(OP_PATTERN, "ab", 1'b1);
    send_str(OP_TEXT, "abab", 1'b1);
    wait_drained();
    write_reg(CFG_MAX_COUNT, 32'd1);
    send_str(OP_TEXT, "abab", 1'b1);
    wait_drained();
    write_reg(CFG_MAX_COUNT, 32'hffff_ffff);
  endtask

  // Text "xxbcbc" searched for "bc" from the right, both fed reversed.
  task automatic test_right_to_left();
    wait_drained();
    write_reg(CFG_DIRECTION, 32'd1);
    send_str(OP_PATTERN, "cb", 1'b1);
    send_str(OP_TEXT, "cbcbxx", 1'b1);
    wait_drained();
    write_reg(CFG_DIRECTION, 32'd0);
  endtask

  task automatic test_pattern_overflow();
    int i;
    for (i = 0; i < PATTERN_MAX_DEF + 2; i++) begin
      send_word(OP_PATTERN, "k", i == PATTERN_MAX_DEF + 1);
    end
    send_str(OP_TEXT, "kk", 1'b1);
  endtask

  // The receiver stops for a long stretch while short texts keep arriving,
  // so the result buffers fill and the input has to stall.
  task automatic test_output_backpressure();
    int i;
    wait_drained();
    idle_on = 1'b0;
    send_str(OP_PATTERN, "a", 1'b1);
    hold_req = 1'b1;
    for (i = 0; i < 12; i++) send_str(OP_TEXT, "aa", 1'b1);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    char_t       alpha [3];
    char_t       pat [$];
    char_t       txt [$];
    int unsigned start_words;
    int unsigned job;
    int unsigned plen;
    int unsigned tlen;
    int          i;
    bit          text_open;
    bit          close_pat;
    bit          close_txt;
    start_words = words_sent;
    job         = 0;
    text_open   = 1'b0;
    while (words_sent - start_words < 1800) begin
      if (job % 16 == 0) begin
        wait_drained();
        case ($urandom_range(0, 6))
          0: write_reg(CFG_MAX_COUNT, '0);
          1: write_reg(CFG_MAX_COUNT, 32'd1);
          2: write_reg(CFG_MAX_COUNT, 32'hffff_ffff);
          3: write_reg(CFG_MAX_COUNT, $urandom);
          default: write_reg(CFG_MAX_COUNT, $urandom_range(1, 4));
        endcase
        write_reg(CFG_DIRECTION, $urandom_range(0, 1));
        idle_on = ($urandom_range(0, 9) < 7);
      end
      // The closing stretch of the run has no idling at all.
      if (words_sent - start_words >= 1500) idle_on = 1'b0;
      if (pat.size() == 0 || text_open || $urandom_range(0, 9) < 7) begin
        foreach (alpha[k]) alpha[k] = char_t'($urandom);
        case ($urandom_range(0, 99)) inside
          [0:79]:  plen = $urandom_range(1, 4);
          [80:95]: plen = $urandom_range(5, PATTERN_MAX_DEF);
          default: plen = $urandom_range(PATTERN_MAX_DEF + 1, PATTERN_MAX_DEF + 4);
        endcase
        pat.delete();
        for (i = 0; i < plen; i++) pat.push_back(alpha[$urandom_range(0, 2)]);
        close_pat = ($urandom_range(0, 9) != 0);
        for (i = 0; i < plen; i++) send_word(OP_PATTERN, pat[i], close_pat && i == plen - 1);
      end
      tlen = $urandom_range(1, 40);
      txt.delete();
      while (txt.size() < tlen) begin
        if ($urandom_range(0, 3) == 0) begin
          foreach (pat[k]) txt.push_back(pat[k]);
        end else if ($urandom_range(0, 19) == 0) begin
          txt.push_back(char_t'($urandom));
        end else begin
          txt.push_back(alpha[$urandom_range(0, 2)]);
        end
      end
      close_txt = (job % 16 == 15) || ($urandom_range(0, 19) != 0);
      for (i = 0; i < txt.size(); i++) begin
        send_word(OP_TEXT, txt[i], close_txt && i == txt.size() - 1);
      end
      text_open = !close_txt;
      job++;
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_MAX_COUNT;
    cfg_wdata = '0;
    hold_req  = 1'b0;
    idle_on   = 1'b1;
    fault_count = 0;
    words_sent  = 0;
    pat_len       = 0;
    pat_ovf       = 1'b0;
    pat_closed    = 1'b1;
    max_count_reg = 32'hffff_ffff;
    dir_reg       = 1'b0;
    clear_scan_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_pattern();
    test_basic_search();
    test_char_extremes();
    test_pattern_longer_than_text();
    test_text_closes_pattern();
    test_abandoned_text();
    test_max_count();
    test_right_to_left();
    test_pattern_overflow();
    test_output_backpressure();
    idle_on = 1'b1;
    test_random_traffic();

    wait_drained();
    repeat (10) @(posedge clk);
    if (fault_count == 0) begin
      $display("substring_find_and_count: match");
    end else begin
      $display("substring_find_and_count: mismatch");
    end
    $finish;
  end

endmodule
